/* src/lsf_pkg.sv */
// ----------------------------------------------------------------------------
// Linear spring pair force package
// Widths, register indexes and shared types of the pair force pipeline.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int DIMENSIONS = 2;
  localparam int NUM_LANES  = 3;

  localparam int COORD_W = 32;
  localparam int MAG_W   = COORD_W + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int OLAP_W  = ROOT_W;
  localparam int UNIT_W  = 31;
  localparam int DIV_STEPS = UNIT_W - 1;
  localparam int PROD1_W = COORD_W + UNIT_W;
  localparam int PROD_W  = PROD1_W + OLAP_W;
  localparam int FRAC_SHIFT = 46;

  localparam logic [OLAP_W-1:0] ONE_Q16 = OLAP_W'(65536);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_EN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_LEN = 2'd2;

  localparam logic [COORD_W-1:0] STIFFNESS_RST  = 32'd983040;
  localparam logic [COORD_W-1:0] CUTOFF_LEN_RST = 32'hFFFF_FFFF;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic [NUM_LANES-1:0] neg;
    logic                 olap_neg;
    logic [OLAP_W-1:0]    olap_mag;
    logic                 coin;
    logic                 beyond;
  } side_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][COORD_W-1:0] force_v;
    logic                              beyond;
    logic                              coin;
  } result_t;

endpackage

/* src/linear_spring_pair_force_unit.sv */
// ----------------------------------------------------------------------------
// Linear spring pair force unit
// Hookean spring force on node a from node b, with optional cutoff.
// ----------------------------------------------------------------------------
// The unit takes one node pair per clock while in_ready is high and returns
// the saturated Q16.16 force on node a, F = k * (d / |d|) * (|d| - 1.0),
// with d = b - a. The pipeline depth is set by the square root (one root
// bit per stage, 33 stages) and the per-lane divider that forms the unit
// vector (one quotient bit per stage, 31 stages), followed by a split wide
// multiply. Every stage carries a valid bit, so a new pair can be taken
// every cycle unless the pipeline is halted. A result register plus one skid
// entry decouple the output: the pipeline keeps moving while a finished
// result waits, and halts only once the skid entry is occupied.
// Coincident nodes give zero force with coincident set; a pair at or beyond
// the cutoff (when enabled) gives zero force with beyond_cutoff set.
// Configuration writes are always taken and should only be issued while no
// pair is in flight.
module linear_spring_pair_force_unit
  import lsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   in_node_a_x,
  input  logic [COORD_W-1:0]   in_node_a_y,
  input  logic [COORD_W-1:0]   in_node_a_z,
  input  logic [COORD_W-1:0]   in_node_b_x,
  input  logic [COORD_W-1:0]   in_node_b_y,
  input  logic [COORD_W-1:0]   in_node_b_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   out_force_x,
  output logic [COORD_W-1:0]   out_force_y,
  output logic [COORD_W-1:0]   out_force_z,
  output logic                 out_beyond_cutoff,
  output logic                 out_coincident,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  // Configuration registers
  logic [COORD_W-1:0] stiffness_r;
  logic               cutoff_en_r;
  logic [COORD_W-1:0] cutoff_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r  <= STIFFNESS_RST;
      cutoff_en_r  <= 1'b0;
      cutoff_len_r <= CUTOFF_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STIFFNESS:  stiffness_r  <= cfg_data;
        CFG_CUTOFF_EN:  cutoff_en_r  <= cfg_data[0];
        CFG_CUTOFF_LEN: cutoff_len_r <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Global pipeline advance: hold everything only while the skid entry is full
  logic skid_v_r;
  logic en;
  assign en       = !skid_v_r;
  assign in_ready = en;

  // Stage 0: difference vector, split into sign and magnitude
  logic [NUM_LANES-1:0][COORD_W-1:0] node_a, node_b;
  logic [NUM_LANES-1:0]              d_neg;
  mag_t                              d_mag [NUM_LANES];

  assign node_a[0] = in_node_a_x;
  assign node_a[1] = in_node_a_y;
  assign node_a[2] = in_node_a_z;
  assign node_b[0] = in_node_b_x;
  assign node_b[1] = in_node_b_y;
  assign node_b[2] = in_node_b_z;

  always_comb begin
    logic [MAG_W-1:0] d;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (i < DIMENSIONS) begin
        d = {node_b[i][COORD_W-1], node_b[i]} - {node_a[i][COORD_W-1], node_a[i]};
      end else begin
        d = '0;
      end
      d_neg[i] = d[MAG_W-1];
      d_mag[i] = d_neg[i] ? (MAG_W'(0) - d) : d;
    end
  end

  logic                 s0_v_r;
  logic [NUM_LANES-1:0] s0_neg_r;
  mag_t                 s0_mag_r [NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_neg_r <= d_neg;
      for (int i = 0; i < NUM_LANES; i++) begin
        s0_mag_r[i] <= d_mag[i];
      end
    end
  end

  // Stage 1: square each component
  logic                 s1_v_r;
  logic [NUM_LANES-1:0] s1_neg_r;
  mag_t                 s1_mag_r [NUM_LANES];
  logic [SQ_W-1:0]      s1_sq_r  [NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg_r <= s0_neg_r;
      for (int i = 0; i < NUM_LANES; i++) begin
        s1_mag_r[i] <= s0_mag_r[i];
        s1_sq_r[i]  <= SQ_W'(s0_mag_r[i]) * SQ_W'(s0_mag_r[i]);
      end
    end
  end

  // Square root pipeline; entry 0 holds the summed squares
  logic                 rt_v_r    [ROOT_W+1];
  logic [NUM_LANES-1:0] rt_neg_r  [ROOT_W+1];
  logic                 rt_coin_r [ROOT_W+1];
  mag_t                 rt_mag_r  [ROOT_W+1][NUM_LANES];
  logic [SQ_W-1:0]      rt_rad_r  [ROOT_W+1];
  logic [REM_W-1:0]     rt_rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0]    rt_root_r [ROOT_W+1];

  logic [SQ_W-1:0] sq_sum;
  assign sq_sum = s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_v_r[0] <= 1'b0;
    end else if (en) begin
      rt_v_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_neg_r[0]  <= s1_neg_r;
      rt_coin_r[0] <= (sq_sum == '0);
      rt_rad_r[0]  <= sq_sum;
      rt_rem_r[0]  <= '0;
      rt_root_r[0] <= '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        rt_mag_r[0][i] <= s1_mag_r[i];
      end
    end
  end

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_root
    logic [REM_W-1:0] rem_cat;
    logic [REM_W-1:0] trial;
    logic             take;

    assign rem_cat = {rt_rem_r[k-1][REM_W-3:0], rt_rad_r[k-1][SQ_W-1 -: 2]};
    assign trial   = REM_W'({rt_root_r[k-1], 2'b01});
    assign take    = (rem_cat >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_v_r[k] <= 1'b0;
      end else if (en) begin
        rt_v_r[k] <= rt_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_neg_r[k]  <= rt_neg_r[k-1];
        rt_coin_r[k] <= rt_coin_r[k-1];
        rt_rad_r[k]  <= {rt_rad_r[k-1][SQ_W-3:0], 2'b00};
        rt_rem_r[k]  <= take ? (rem_cat - trial) : rem_cat;
        rt_root_r[k] <= {rt_root_r[k-1][ROOT_W-2:0], take};
        for (int i = 0; i < NUM_LANES; i++) begin
          rt_mag_r[k][i] <= rt_mag_r[k-1][i];
        end
      end
    end
  end

  // Divider pipeline for the unit vector; entry 0 also resolves the cutoff
  logic              dv_v_r    [DIV_STEPS+1];
  side_t             dv_side_r [DIV_STEPS+1];
  logic [OLAP_W-1:0] dv_dist_r [DIV_STEPS+1];
  logic [MAG_W-1:0]  dv_rem_r  [DIV_STEPS+1][NUM_LANES];
  logic [UNIT_W-1:0] dv_q_r    [DIV_STEPS+1][NUM_LANES];

  logic [OLAP_W-1:0] dist_val;
  side_t             side0;
  assign dist_val = rt_root_r[ROOT_W];

  always_comb begin
    side0.neg      = rt_neg_r[ROOT_W];
    side0.coin     = rt_coin_r[ROOT_W];
    side0.beyond   = cutoff_en_r && !rt_coin_r[ROOT_W] &&
                     (dist_val >= OLAP_W'(cutoff_len_r));
    side0.olap_neg = (dist_val < ONE_Q16);
    side0.olap_mag = side0.olap_neg ? (ONE_Q16 - dist_val) : (dist_val - ONE_Q16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= rt_v_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    logic ge;
    if (en) begin
      dv_side_r[0] <= side0;
      dv_dist_r[0] <= dist_val;
      for (int i = 0; i < NUM_LANES; i++) begin
        ge = (rt_mag_r[ROOT_W][i] >= dist_val);
        dv_rem_r[0][i] <= ge ? (rt_mag_r[ROOT_W][i] - dist_val) : rt_mag_r[ROOT_W][i];
        dv_q_r[0][i]   <= UNIT_W'(ge);
      end
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (en) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      logic [MAG_W:0] rem2;
      logic           ge;
      if (en) begin
        dv_side_r[k] <= dv_side_r[k-1];
        dv_dist_r[k] <= dv_dist_r[k-1];
        for (int i = 0; i < NUM_LANES; i++) begin
          rem2 = {dv_rem_r[k-1][i], 1'b0};
          ge   = (rem2 >= (MAG_W+1)'(dv_dist_r[k-1]));
          dv_rem_r[k][i] <= ge ? MAG_W'(rem2 - (MAG_W+1)'(dv_dist_r[k-1]))
                               : MAG_W'(rem2);
          dv_q_r[k][i]   <= {dv_q_r[k-1][i][UNIT_W-2:0], ge};
        end
      end
    end
  end

  // Multiply stage 1: stiffness times unit component
  logic               m1_v_r;
  side_t              m1_side_r;
  logic [PROD1_W-1:0] m1_p_r [NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_side_r <= dv_side_r[DIV_STEPS];
      for (int i = 0; i < NUM_LANES; i++) begin
        m1_p_r[i] <= PROD1_W'(stiffness_r) * PROD1_W'(dv_q_r[DIV_STEPS][i]);
      end
    end
  end

  // Multiply stage 2: partial products of the overlap multiply
  localparam int LO_W = COORD_W + OLAP_W;
  localparam int HI_W = (PROD1_W - COORD_W) + OLAP_W;

  logic            m2_v_r;
  side_t           m2_side_r;
  logic [LO_W-1:0] m2_lo_r [NUM_LANES];
  logic [HI_W-1:0] m2_hi_r [NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (en) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_side_r <= m1_side_r;
      for (int i = 0; i < NUM_LANES; i++) begin
        m2_lo_r[i] <= LO_W'(m1_p_r[i][COORD_W-1:0]) * LO_W'(m1_side_r.olap_mag);
        m2_hi_r[i] <= HI_W'(m1_p_r[i][PROD1_W-1:COORD_W]) * HI_W'(m1_side_r.olap_mag);
      end
    end
  end

  // Multiply stage 3: combine partial products
  logic              m3_v_r;
  side_t             m3_side_r;
  logic [PROD_W-1:0] m3_prod_r [NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else if (en) begin
      m3_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_side_r <= m2_side_r;
      for (int i = 0; i < NUM_LANES; i++) begin
        m3_prod_r[i] <= PROD_W'({m2_hi_r[i], COORD_W'(0)}) + PROD_W'(m2_lo_r[i]);
      end
    end
  end

  // Stage 4: scale, saturate, apply sign, zero on the special cases
  localparam int HI_BITS = PROD_W - FRAC_SHIFT;

  logic    fin_v_r;
  result_t fin_r;
  result_t fin_nxt;

  always_comb begin
    logic               fneg;
    logic [HI_BITS-1:0] mag_hi;
    logic [HI_BITS-1:0] limit;
    logic [COORD_W-1:0] f;
    fin_nxt.beyond = m3_side_r.beyond;
    fin_nxt.coin   = m3_side_r.coin;
    for (int i = 0; i < NUM_LANES; i++) begin
      fneg   = m3_side_r.neg[i] ^ m3_side_r.olap_neg;
      mag_hi = m3_prod_r[i][PROD_W-1:FRAC_SHIFT];
      limit  = fneg ? HI_BITS'(33'h0_8000_0000) : HI_BITS'(33'h0_7FFF_FFFF);
      f      = (mag_hi > limit) ? limit[COORD_W-1:0] : mag_hi[COORD_W-1:0];
      if (m3_side_r.coin || m3_side_r.beyond) begin
        fin_nxt.force_v[i] = '0;
      end else begin
        fin_nxt.force_v[i] = fneg ? (COORD_W'(0) - f) : f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= m3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  // Output register and skid entry
  logic    out_v_r;
  result_t out_r;
  result_t skid_r;
  logic    out_free;

  assign out_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= fin_v_r;
      end
    end else if (fin_v_r && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_v_r ? skid_r : fin_r;
    end else if (en) begin
      skid_r <= fin_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_force_x       = out_r.force_v[0];
  assign out_force_y       = out_r.force_v[1];
  assign out_force_z       = out_r.force_v[2];
  assign out_beyond_cutoff = out_r.beyond;
  assign out_coincident    = out_r.coin;

endmodule

/* sim/linear_spring_pair_force_unit_test.sv */
// ----------------------------------------------------------------------------
// Linear spring pair force unit testbench
// Streams node pairs through the unit, predicts each force from a local
// fixed-point model, and checks results in order under random stalls.
// ----------------------------------------------------------------------------
module linear_spring_pair_force_unit_test
  import lsf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] ax, ay, az, bx, by, bz;
  } pair_t;

  typedef struct {
    logic [31:0] fx, fy, fz;
    logic        beyond, coin;
  } force_t;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic [31:0] in_node_a_x = '0, in_node_a_y = '0, in_node_a_z = '0;
  logic [31:0] in_node_b_x = '0, in_node_b_y = '0, in_node_b_z = '0;
  logic out_valid, out_ready = 1'b0;
  logic [31:0] out_force_x, out_force_y, out_force_z;
  logic out_beyond_cutoff, out_coincident;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Model copy of the configuration registers.
  logic [31:0] stiffness;
  logic        cut_en;
  logic [31:0] cut_len;

  pair_t  pending_pairs[$];
  force_t expected_forces[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     hold_off = 0;     // long receiver stall, set by the stimulus
  int     in_wait = 0, out_wait = 0;
  logic   in_fire = 1'b0;   // input transfer seen at the last rising edge

  linear_spring_pair_force_unit dut (.*);

  always #10 clk = ~clk;

  // Floor square root of a 66-bit value, one result bit at a time.
  function automatic logic [33:0] isqrt(input logic [65:0] s);
    logic [33:0] r;
    logic [67:0] t;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      t = 68'(r | (34'd1 << b));
      if (t * t <= 68'(s)) r = r | (34'd1 << b);
    end
    return r;
  endfunction

  function automatic force_t spring_force(input pair_t p);
    force_t r;
    logic signed [32:0] d[3];
    logic [32:0]  mag[3];
    logic [65:0]  sq;
    logic [33:0]  dist_val, olap;
    logic         olap_neg, fneg;
    logic [63:0]  unit;
    logic [159:0] prod;
    logic [159:0] f, lim;
    logic [31:0]  res[3];
    d[0] = $signed(p.bx) - $signed(p.ax);
    d[1] = (DIMENSIONS > 1) ? $signed(p.by) - $signed(p.ay) : 33'sd0;
    d[2] = (DIMENSIONS > 2) ? $signed(p.bz) - $signed(p.az) : 33'sd0;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      sq += 66'(mag[i]) * 66'(mag[i]);
      res[i] = '0;
    end
    r.beyond = 1'b0;
    r.coin = (sq == 0);
    if (!r.coin) begin
      dist_val = isqrt(sq);
      if (cut_en && dist_val >= 34'(cut_len)) r.beyond = 1'b1;
      else begin
        olap_neg = dist_val < 34'd65536;
        olap = olap_neg ? 34'd65536 - dist_val : dist_val - 34'd65536;
        for (int i = 0; i < 3; i++) begin
          if (mag[i] != 0) begin
            unit = (64'(mag[i]) << 30) / 64'(dist_val);
            prod = 160'(stiffness) * 160'(unit) * 160'(olap);
            f = prod >> 46;
            fneg = d[i][32] != olap_neg;
            lim = fneg ? 160'h8000_0000 : 160'h7FFF_FFFF;
            if (f > lim) f = lim;
            res[i] = fneg ? 32'(-f[31:0]) : f[31:0];
          end
        end
      end
    end
    r.fx = res[0];
    r.fy = res[1];
    r.fz = res[2];
    return r;
  endfunction

  // Record input transfers at the edge where they happen.
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
  end

  // Driver: hold each pair until transfer, then draw the next gap.
  always @(negedge clk) begin
    int gap;
    if (rst_n) begin
      if (in_fire) begin
        expected_forces.push_back(spring_force(pending_pairs.pop_front()));
        gap = $urandom_range(0, 4);
        if (gap == 0 && pending_pairs.size() > 0) begin
          in_node_a_x <= pending_pairs[0].ax;
          in_node_a_y <= pending_pairs[0].ay;
          in_node_a_z <= pending_pairs[0].az;
          in_node_b_x <= pending_pairs[0].bx;
          in_node_b_y <= pending_pairs[0].by;
          in_node_b_z <= pending_pairs[0].bz;
          in_valid <= 1'b1;
        end else begin
          in_wait <= (gap > 0) ? gap - 1 : 0;
          in_valid <= 1'b0;
        end
      end else if (!in_valid && in_wait > 0) begin
        in_wait <= in_wait - 1;
      end else if (!in_valid && pending_pairs.size() > 0) begin
        in_node_a_x <= pending_pairs[0].ax;
        in_node_a_y <= pending_pairs[0].ay;
        in_node_a_z <= pending_pairs[0].az;
        in_node_b_x <= pending_pairs[0].bx;
        in_node_b_y <= pending_pairs[0].by;
        in_node_b_z <= pending_pairs[0].bz;
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver readiness: long hold-off first, else a random gap per result.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check each result transfer against the oldest prediction.
  always @(posedge clk) begin
    force_t e;
    if (rst_n && out_valid && out_ready) begin
      out_wait <= $urandom_range(0, 4);
      if (expected_forces.size() == 0) begin
        $error("result with no pending prediction");
        errors++;
      end else begin
        e = expected_forces.pop_front();
        if (out_force_x !== e.fx) begin
          $error("force_x expected %h got %h", e.fx, out_force_x); errors++;
        end
        if (out_force_y !== e.fy) begin
          $error("force_y expected %h got %h", e.fy, out_force_y); errors++;
        end
        if (out_force_z !== e.fz) begin
          $error("force_z expected %h got %h", e.fz, out_force_z); errors++;
        end
        if (out_beyond_cutoff !== e.beyond) begin
          $error("beyond_cutoff expected %b got %b", e.beyond, out_beyond_cutoff);
          errors++;
        end
        if (out_coincident !== e.coin) begin
          $error("coincident expected %b got %b", e.coin, out_coincident);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on any channel while work is pending.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        (pending_pairs.size() == 0 && expected_forces.size() == 0 && !in_valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_STIFFNESS:  stiffness = val;
      CFG_CUTOFF_EN:  cut_en = val[0];
      CFG_CUTOFF_LEN: cut_len = val;
      default: ;
    endcase
  endtask

  // Wait until every queued pair has come back, then let the pipe settle.
  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_forces.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 8) << 16;                  // near rest length
      2: return 32'($signed($urandom_range(0, 600000)) - 300000);
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic add_pair(input logic [31:0] ax, ay, az, bx, by, bz);
    pair_t p;
    p.ax = ax; p.ay = ay; p.az = az; p.bx = bx; p.by = by; p.bz = bz;
    pending_pairs.push_back(p);
  endtask

  task automatic random_pairs(input int n);
    int m;
    logic [31:0] ax, ay;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(0, 3);
      ax = rnd_coord(m);
      ay = rnd_coord(m);
      // Keep most pairs close so forces stay in range; some are coincident.
      if ($urandom_range(0, 19) == 0)
        add_pair(ax, ay, $urandom(), ax, ay, $urandom());
      else if (m == 0)
        add_pair(ax, ay, $urandom(), $urandom(), $urandom(), $urandom());
      else
        add_pair(ax, ay, $urandom(), ax + rnd_coord(m), ay + rnd_coord(m), $urandom());
    end
  endtask

  initial begin
    stiffness = STIFFNESS_RST;
    cut_en = 1'b0;
    cut_len = CUTOFF_LEN_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, coincidence, rest length, axis-aligned pulls.
    add_pair(0, 0, 0, 0, 0, 0);
    add_pair(32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
    add_pair(0, 0, 0, 32'h0001_0000, 0, 0);
    add_pair(0, 0, 0, 0, 32'hFFFF_0000, 0);
    add_pair(0, 0, 0, 32'h0000_8000, 0, 0);
    add_pair(0, 0, 0, 1, 0, 0);
    add_pair(0, 0, 0, 32'h0003_0000, 32'h0004_0000, 32'h1234_5678);
    add_pair(32'h0001_0000, 32'h0002_0000, 0, 32'hFFFE_0000, 32'h0001_8000, 0);
    add_pair(5, 5, 32'hFFFF_FFFF, 5, 5, 0);
    drain();

    write_reg(CFG_CUTOFF_EN, 1);
    write_reg(CFG_CUTOFF_LEN, 32'h0005_0000);
    add_pair(0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0);   // exactly at cutoff
    add_pair(0, 0, 0, 32'h0003_0000, 32'h0003_FFFF, 0);   // just inside
    add_pair(0, 0, 0, 0, 0, 0);                           // coincident wins
    random_pairs(80);
    drain();

    write_reg(CFG_STIFFNESS, 32'hFFFF_FFFF);
    write_reg(CFG_CUTOFF_LEN, 0);
    random_pairs(40);
    drain();

    write_reg(CFG_CUTOFF_EN, 0);
    write_reg(CFG_STIFFNESS, 1);
    random_pairs(80);
    drain();

    write_reg(CFG_STIFFNESS, 32'h0001_0000);
    write_reg(CFG_CUTOFF_EN, 1);
    write_reg(CFG_CUTOFF_LEN, 32'hFFFF_FFFF);
    // Stall the receiver long enough to back up the pipeline.
    hold_off = 300;
    random_pairs(150);
    drain();

    write_reg(CFG_STIFFNESS, $urandom());
    write_reg(CFG_CUTOFF_LEN, $urandom_range(0, 32'h0010_0000));
    random_pairs(150);
    drain();

    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* linear_spring_pair_force_unit.f */
src/lsf_pkg.sv
src/linear_spring_pair_force_unit.sv
sim/linear_spring_pair_force_unit_test.sv
